// ===== sv/bbf_pkg.sv =====
package bbf_pkg;

    localparam int DEPTH_BITS = 16;
    localparam int OFFSET_BITS = 32;

    localparam logic [7:0] CHAR_SLASH = 8'h2F;
    localparam logic [7:0] CHAR_STAR = 8'h2A;
    localparam logic [7:0] CHAR_LBRACE = 8'h7B;
    localparam logic [7:0] CHAR_RBRACE = 8'h7D;
    localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
    localparam logic [7:0] CHAR_NUL = 8'h00;

    typedef enum logic [2:0] {
        MODE_NORMAL = 3'd0,
        MODE_SLASH = 3'd1,
        MODE_LINE = 3'd2,
        MODE_BLOCK = 3'd3,
        MODE_BLOCK_STAR = 3'd4
    } mode_t;

    typedef enum logic [1:0] {
        STATUS_FOUND = 2'd0,
        STATUS_FAIL = 2'd1,
        STATUS_OVERFLOW = 2'd2
    } status_t;

    typedef struct packed {
        logic [7:0] byte_value;
        logic       last_byte;
    } item_t;

    typedef struct packed {
        status_t                status;
        logic [OFFSET_BITS-1:0] block_start;
        logic [OFFSET_BITS-1:0] block_end;
    } result_t;

endpackage

// ===== sv/bbf_in_stage.sv =====
module bbf_in_stage (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  bbf_pkg::item_t s_item,
    output logic          item_valid,
    output bbf_pkg::item_t item,
    input  logic          item_take
);
    import bbf_pkg::*;

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;

    assign s_tready = !valid_reg || item_take;

    always_comb begin
        valid_next = valid_reg;
        if (s_tready) begin
            valid_next = s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        if (s_tvalid && s_tready) begin
            item_reg <= s_item;
        end
    end

    assign item_valid = valid_reg;
    assign item = item_reg;
endmodule

// ===== sv/bbf_scan.sv =====
module bbf_scan (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_fire,
    input  logic [bbf_pkg::OFFSET_BITS-1:0]   cfg_value,
    input  logic                              fire,
    input  bbf_pkg::item_t                    item,
    output logic                              res_valid,
    output bbf_pkg::result_t                  res
);
    import bbf_pkg::*;

    localparam logic [DEPTH_BITS-1:0] DEPTH_MAX = '1;
    localparam logic [DEPTH_BITS-1:0] DEPTH_ONE = DEPTH_BITS'(1);

    logic [OFFSET_BITS-1:0] base_reg, base_next;
    logic [OFFSET_BITS-1:0] pos_reg, pos_next;
    logic [OFFSET_BITS-1:0] open_reg, open_next;
    logic [DEPTH_BITS-1:0]  depth_reg, depth_next;
    mode_t                  mode_reg, mode_next;
    logic                   done_reg, done_next;
    logic                   begun_reg, begun_next;
    logic                   plain;
    logic [7:0]             c;

    assign c = item.byte_value;

    always_comb begin
        base_next = base_reg;
        pos_next = pos_reg;
        open_next = open_reg;
        depth_next = depth_reg;
        mode_next = mode_reg;
        done_next = done_reg;
        begun_next = begun_reg;
        plain = 1'b0;
        res_valid = 1'b0;
        res.status = STATUS_FAIL;
        res.block_start = open_reg;
        res.block_end = '0;

        if (fire && !done_reg) begin
            begun_next = 1'b1;
            pos_next = pos_reg + OFFSET_BITS'(1);
            unique case (mode_reg)
                MODE_SLASH: begin
                    if (c == CHAR_SLASH) begin
                        mode_next = MODE_LINE;
                    end else if (c == CHAR_STAR) begin
                        mode_next = MODE_BLOCK_STAR;
                    end else begin
                        plain = 1'b1;
                    end
                end
                MODE_LINE: begin
                    plain = (c == CHAR_NEWLINE) || (c == CHAR_NUL);
                end
                MODE_BLOCK: begin
                    if (c == CHAR_STAR) begin
                        mode_next = MODE_BLOCK_STAR;
                    end
                end
                MODE_BLOCK_STAR: begin
                    if (c == CHAR_SLASH) begin
                        mode_next = MODE_NORMAL;
                    end else if (c != CHAR_STAR) begin
                        mode_next = MODE_BLOCK;
                    end
                end
                default: begin
                    plain = 1'b1;
                end
            endcase

            if (plain) begin
                mode_next = (c == CHAR_SLASH) ? MODE_SLASH : MODE_NORMAL;
                if (c == CHAR_RBRACE) begin
                    if (depth_reg == '0) begin
                        res_valid = 1'b1;
                        res.status = STATUS_FAIL;
                        res.block_start = base_reg;
                    end else if (depth_reg == DEPTH_ONE) begin
                        res_valid = 1'b1;
                        res.status = STATUS_FOUND;
                        res.block_start = open_reg;
                        res.block_end = pos_reg;
                    end else begin
                        depth_next = depth_reg - DEPTH_ONE;
                    end
                end else if (c == CHAR_LBRACE) begin
                    if (depth_reg == DEPTH_MAX) begin
                        res_valid = 1'b1;
                        res.status = STATUS_OVERFLOW;
                        res.block_start = open_reg;
                    end else begin
                        if (depth_reg == '0) begin
                            open_next = pos_reg + OFFSET_BITS'(1);
                        end
                        depth_next = depth_reg + DEPTH_ONE;
                    end
                end
            end

            if (item.last_byte && !res_valid) begin
                res_valid = 1'b1;
                res.status = STATUS_FAIL;
                res.block_start = open_next;
            end
            if (res_valid) begin
                done_next = 1'b1;
            end
        end

        if (fire && item.last_byte) begin
            pos_next = base_reg;
            open_next = base_reg;
            depth_next = '0;
            mode_next = MODE_NORMAL;
            done_next = 1'b0;
            begun_next = 1'b0;
        end

        // A new base offset also moves the position of a scan that has no byte yet.
        if (cfg_fire) begin
            base_next = cfg_value;
            if (!begun_reg) begin
                pos_next = cfg_value;
                open_next = cfg_value;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_reg <= '0;
            pos_reg <= '0;
            open_reg <= '0;
            depth_reg <= '0;
            mode_reg <= MODE_NORMAL;
            done_reg <= 1'b0;
            begun_reg <= 1'b0;
        end else begin
            base_reg <= base_next;
            pos_reg <= pos_next;
            open_reg <= open_next;
            depth_reg <= depth_next;
            mode_reg <= mode_next;
            done_reg <= done_next;
            begun_reg <= begun_next;
        end
    end
endmodule

// ===== sv/bbf_out_stage.sv =====
module bbf_out_stage (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             res_valid,
    input  bbf_pkg::result_t res,
    output logic             out_free,
    output logic             m_tvalid,
    input  logic             m_tready,
    output bbf_pkg::result_t m_res
);
    import bbf_pkg::*;

    logic    valid_reg;
    result_t res_reg;

    assign out_free = !valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (out_free) begin
            valid_reg <= res_valid;
        end
        if (out_free && res_valid) begin
            res_reg <= res;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_res = res_reg;
endmodule

// ===== sv/comment_aware_brace_block_finder_top.sv =====
// A result request is presented on m_tvalid from the output register; the byte that causes it
// passes the input register and the combinational scan before it reaches that register.
// One byte per cycle while out_free is high; lexer and depth update are combinational.
// A result waiting in the output register while m_tready is low stalls all bytes.
// Reset (aresetn low at a clock edge) clears base_offset to zero and rearms the scan.
// The configuration channel is always ready.
module comment_aware_brace_block_finder_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [31:0] cfg_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // byte_value
    input  logic        s_tlast,   // last_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // block_start, block_end
    output logic [1:0]  m_tuser    // status
);
    import bbf_pkg::*;

    item_t   s_item;
    item_t   item;
    logic    item_valid;
    logic    out_free;
    logic    fire;
    logic    res_valid;
    result_t res;
    result_t m_res;

    assign cfg_ready = 1'b1;
    assign s_item.byte_value = s_tdata;
    assign s_item.last_byte = s_tlast;
    assign fire = item_valid && out_free;

    bbf_in_stage u_in (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_item    (s_item),
        .item_valid(item_valid),
        .item      (item),
        .item_take (out_free)
    );

    bbf_scan u_scan (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_fire (cfg_valid && cfg_ready),
        .cfg_value(cfg_data),
        .fire     (fire),
        .item     (item),
        .res_valid(res_valid),
        .res      (res)
    );

    bbf_out_stage u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .res_valid(res_valid),
        .res      (res),
        .out_free (out_free),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_res    (m_res)
    );

    assign m_tdata = {m_res.block_end, m_res.block_start};
    assign m_tuser = m_res.status;
endmodule
